>>> hw/rtl/bm3_pkg.sv
// ----------------------------------------------------------------------------
// bm3_pkg: shared types and constants of the 3x3 binary morphology block
// Sizes, register indexes, pixel classes, config bundle and queue entry.
// ----------------------------------------------------------------------------
package bm3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Fixed field widths
  localparam int PIX_W      = 8;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_ADDR_W = 3;
  localparam int MASK_W     = 9;

  // Derived widths
  localparam int SIZE_W = $clog2((MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
  localparam int POS_W  = $clog2((MAX_HEIGHT + 2) * MAX_WIDTH);
  localparam int TOT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int OCNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT);

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_OPERATION  = 3'd0,
    REG_ELEM_MODE  = 3'd1,
    REG_FOREGROUND = 3'd2,
    REG_MASK       = 3'd3,
    REG_WIDTH      = 3'd4,
    REG_HEIGHT     = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_ERODE  = 2'd0,
    OP_DILATE = 2'd1,
    OP_OUTER  = 2'd2,
    OP_INNER  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ELEM_HORIZ  = 2'd0,
    ELEM_VERT   = 2'd1,
    ELEM_CUSTOM = 2'd2
  } elem_t;

  // Pixel class: black, white, or anything else
  typedef enum logic [1:0] {
    CLS_ZERO  = 2'd0,
    CLS_FULL  = 2'd1,
    CLS_OTHER = 2'd2
  } pix_cls_t;

  // 3x3 window of classes, cell index 3*row+col; row 0 oldest line, row 2 newest
  typedef logic [8:0][1:0] win_t;

  typedef struct packed {
    op_t                op;
    elem_t              elem;
    logic               fg;
    logic [MASK_W-1:0]  mask;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic [TOT_W-1:0]   total;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [SIZE_W-1:0] width;
  } width_upd_t;

  typedef struct packed {
    win_t win;
    logic proc;
    logic last;
    logic err;
  } job_t;

endpackage

>>> hw/rtl/bm3_cfg.sv
// ----------------------------------------------------------------------------
// bm3_cfg: configuration registers
// Decodes writes, clamps frame sizes and keeps the pixel total of the frame.
// ----------------------------------------------------------------------------
module bm3_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bm3_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [bm3_pkg::CFG_DATA_W-1:0]    cfg_data,
  output bm3_pkg::cfg_t                     cfg,
  output bm3_pkg::width_upd_t               wupd
);
  import bm3_pkg::*;

  localparam int CMP_W  = CFG_DATA_W + SIZE_W;
  localparam int PROD_W = 2 * SIZE_W;

  op_t               op_r, op_nxt;
  elem_t             elem_r, elem_nxt;
  logic              fg_r, fg_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic [SIZE_W-1:0] width_r, width_nxt;
  logic [SIZE_W-1:0] height_r, height_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [SIZE_W-1:0] w_clamp, h_clamp;
  logic [PROD_W-1:0] prod;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_DATA_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    if (CMP_W'(v) < CMP_W'(3)) begin
      r = SIZE_W'(3);
    end else if (CMP_W'(v) > CMP_W'(hi)) begin
      r = hi;
    end else begin
      r = SIZE_W'(v);
    end
    return r;
  endfunction

  assign w_clamp = clamp_size(cfg_data, SIZE_W'(MAX_WIDTH));
  assign h_clamp = clamp_size(cfg_data, SIZE_W'(MAX_HEIGHT));

  always_comb begin
    op_nxt     = op_r;
    elem_nxt   = elem_r;
    fg_nxt     = fg_r;
    mask_nxt   = mask_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_OPERATION:  op_nxt = op_t'(cfg_data[1:0]);
        REG_ELEM_MODE: begin
          unique case (cfg_data[1:0])
            2'd0:    elem_nxt = ELEM_HORIZ;
            2'd1:    elem_nxt = ELEM_VERT;
            default: elem_nxt = ELEM_CUSTOM;
          endcase
        end
        REG_FOREGROUND: fg_nxt = cfg_data[0];
        REG_MASK:       mask_nxt = cfg_data[MASK_W-1:0];
        REG_WIDTH:      width_nxt = w_clamp;
        REG_HEIGHT:     height_nxt = h_clamp;
        default: ;
      endcase
    end
    // New total follows from the size values after this write
    prod      = PROD_W'(width_nxt) * PROD_W'(height_nxt);
    total_nxt = TOT_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r     <= OP_ERODE;
      elem_r   <= ELEM_HORIZ;
      fg_r     <= 1'b0;
      mask_r   <= '1;
      width_r  <= SIZE_W'(MAX_WIDTH);
      height_r <= SIZE_W'(MAX_HEIGHT);
      total_r  <= TOT_W'(MAX_WIDTH * MAX_HEIGHT);
    end else begin
      op_r     <= op_nxt;
      elem_r   <= elem_nxt;
      fg_r     <= fg_nxt;
      mask_r   <= mask_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      total_r  <= total_nxt;
    end
  end

  assign cfg.op     = op_r;
  assign cfg.elem   = elem_r;
  assign cfg.fg     = fg_r;
  assign cfg.mask   = mask_r;
  assign cfg.width  = width_r;
  assign cfg.height = height_r;
  assign cfg.total  = total_r;

  assign wupd.we    = cfg_we && (cfg_reg_t'(cfg_addr) == REG_WIDTH);
  assign wupd.width = w_clamp;

endmodule

>>> hw/rtl/bm3_front.sv
// ----------------------------------------------------------------------------
// bm3_front: pixel intake, position tracking, line store and 3x3 window
// Classifies each beat, decides whether it yields a result and whether the
// centre is processed, and pushes the finished window to the queue.
// ----------------------------------------------------------------------------
module bm3_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bm3_pkg::PIX_W-1:0]      in_tdata,
  input  logic                           in_tuser,
  input  bm3_pkg::cfg_t                  cfg,
  input  bm3_pkg::width_upd_t            wupd,
  input  logic [bm3_pkg::Q_CNT_W-1:0]    q_level,
  output logic                           push,
  output bm3_pkg::job_t                  push_job
);
  import bm3_pkg::*;

  localparam int CW     = POS_W;
  localparam int LVL_W  = Q_CNT_W + 1;
  localparam int PROD_W = ROW_W + SIZE_W;

  // Clearing sweep of the line store after reset
  logic             clr_done_r, clr_done_nxt;
  logic [COL_W-1:0] clr_addr_r, clr_addr_nxt;

  // Stream position
  logic [COL_W-1:0]  col_r, col_nxt, col0;
  logic [ROW_W-1:0]  row_r, row_nxt, row0;
  logic [POS_W-1:0]  pos_r, pos_nxt, pos0;
  logic [OCNT_W-1:0] ocnt_r, ocnt_nxt, ocnt0;

  logic              accept, restart, in_frame, ign, has_res, is_last, wrap;
  logic              col_ok, row_ok, proc;
  logic [1:0]        cur;
  logic [POS_W-1:0]  ocnt_val;
  logic [CW-1:0]     crow, ccol;
  logic [PROD_W-1:0] wprod;
  logic [LVL_W-1:0]  lvl;

  // Line store: [3:2] upper line, [1:0] middle line
  logic [3:0] lmem [MAX_WIDTH];
  logic [3:0] rd_r;

  // Window stage
  logic             s1_v_r, s1_adv_r, s1_clr_r, s1_res_r;
  logic [COL_W-1:0] s1_col_r;
  logic [1:0]       s1_cur_r;
  logic             s1_proc_r, s1_last_r;
  win_t             win_r, win_nxt;
  logic             err_r, err_nxt, err_b;

  function automatic logic [1:0] classify(input logic [PIX_W-1:0] v);
    logic [1:0] c;
    if (v == '0) begin
      c = CLS_ZERO;
    end else if (v == '1) begin
      c = CLS_FULL;
    end else begin
      c = CLS_OTHER;
    end
    return c;
  endfunction

  assign lvl       = LVL_W'(q_level) + LVL_W'(s1_v_r);
  assign in_tready = clr_done_r && (lvl < LVL_W'(Q_DEPTH));
  assign accept    = in_tvalid && in_tready;
  assign wprod     = PROD_W'(row_r) * PROD_W'(wupd.width);

  always_comb begin
    restart = (CW'(col_r) >= CW'(cfg.width)) || (CW'(row_r) > CW'(cfg.height)) ||
              (TOT_W'(ocnt_r) >= cfg.total);
    col0  = restart ? '0 : col_r;
    row0  = restart ? '0 : row_r;
    pos0  = restart ? '0 : pos_r;
    ocnt0 = restart ? '0 : ocnt_r;

    in_frame = CW'(row0) < CW'(cfg.height);
    ign      = in_frame && in_tuser;
    cur      = in_frame ? classify(in_tdata) : CLS_OTHER;
    has_res  = (row0 >= ROW_W'(2)) || ((row0 == ROW_W'(1)) && (col0 != '0));
    ocnt_val = pos0 - POS_W'(cfg.width);
    is_last  = CW'(ocnt_val) == CW'(cfg.total);
    wrap     = CW'(col0) == (CW'(cfg.width) - CW'(1));

    // Centre sits one line and one pixel behind the incoming beat
    if (col0 != '0) begin
      crow = CW'(row0) - CW'(1);
      ccol = CW'(col0) - CW'(1);
    end else begin
      crow = CW'(row0) - CW'(2);
      ccol = CW'(cfg.width) - CW'(1);
    end
    col_ok = (ccol >= CW'(1)) && ((ccol + CW'(1)) < CW'(cfg.width));
    row_ok = (crow >= CW'(1)) && ((crow + CW'(1)) < CW'(cfg.height));
    unique case (cfg.elem)
      ELEM_HORIZ: proc = col_ok;
      ELEM_VERT:  proc = row_ok;
      default:    proc = col_ok && row_ok;
    endcase

    col_nxt  = col_r;
    row_nxt  = row_r;
    pos_nxt  = pos_r;
    ocnt_nxt = ocnt_r;
    if (accept) begin
      col_nxt  = col0;
      row_nxt  = row0;
      pos_nxt  = pos0;
      ocnt_nxt = ocnt0;
      if (!ign) begin
        col_nxt = wrap ? '0 : col0 + COL_W'(1);
        row_nxt = wrap ? row0 + ROW_W'(1) : row0;
        pos_nxt = pos0 + POS_W'(1);
        if (has_res) begin
          ocnt_nxt = ocnt_val[OCNT_W-1:0];
          if (is_last) begin
            col_nxt  = '0;
            row_nxt  = '0;
            pos_nxt  = '0;
            ocnt_nxt = '0;
          end
        end
      end
    end else if (wupd.we) begin
      // Re-base the linear position on the new line length
      pos_nxt = POS_W'(wprod) + POS_W'(col_r);
    end

    clr_addr_nxt = clr_addr_r;
    clr_done_nxt = clr_done_r;
    if (!clr_done_r) begin
      clr_addr_nxt = clr_addr_r + COL_W'(1);
      clr_done_nxt = (clr_addr_r == COL_W'(MAX_WIDTH - 1));
    end
  end

  // Line store write: sweep after reset, then roll middle into upper
  always_ff @(posedge clk) begin
    if (!clr_done_r) begin
      lmem[clr_addr_r] <= '0;
    end else if (s1_v_r && s1_adv_r) begin
      lmem[s1_col_r] <= {rd_r[1:0], s1_cur_r};
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !ign) begin
      rd_r <= lmem[col0];
    end
  end

  // Window shift, sticky error and queue push
  always_comb begin
    win_nxt = win_r;
    for (int r = 0; r < 3; r++) begin
      win_nxt[3*r]     = win_r[3*r + 1];
      win_nxt[3*r + 1] = win_r[3*r + 2];
    end
    win_nxt[2] = rd_r[3:2];
    win_nxt[5] = rd_r[1:0];
    win_nxt[8] = s1_cur_r;

    err_b = s1_clr_r ? 1'b0 : err_r;
    if (s1_adv_r && s1_res_r && s1_proc_r && (win_nxt[4] == CLS_OTHER)) begin
      err_b = 1'b1;
    end
    err_nxt = err_r;
    if (s1_v_r) begin
      err_nxt = (s1_adv_r && s1_res_r && s1_last_r) ? 1'b0 : err_b;
    end

    push          = s1_v_r && s1_adv_r && s1_res_r;
    push_job.win  = win_nxt;
    push_job.proc = s1_proc_r;
    push_job.last = s1_last_r;
    push_job.err  = err_b;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r  <= col0;
      s1_cur_r  <= cur;
      s1_proc_r <= proc;
      s1_last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_done_r <= 1'b0;
      clr_addr_r <= '0;
      col_r      <= '0;
      row_r      <= '0;
      pos_r      <= '0;
      ocnt_r     <= '0;
      s1_v_r     <= 1'b0;
      s1_adv_r   <= 1'b0;
      s1_clr_r   <= 1'b0;
      s1_res_r   <= 1'b0;
      win_r      <= '0;
      err_r      <= 1'b0;
    end else begin
      clr_done_r <= clr_done_nxt;
      clr_addr_r <= clr_addr_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      pos_r      <= pos_nxt;
      ocnt_r     <= ocnt_nxt;
      s1_v_r     <= accept;
      s1_adv_r   <= accept && !ign;
      s1_clr_r   <= accept && restart;
      s1_res_r   <= accept && !ign && has_res;
      if (s1_v_r && s1_adv_r) begin
        win_r <= win_nxt;
      end
      err_r      <= err_nxt;
    end
  end

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_done_r |-> !in_tready)
    else $error("input ready during line store clearing");

  a_beat_reaches_window: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted beat did not reach the window stage");

  a_error_clears_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_adv_r && s1_res_r && s1_last_r) |=> !err_r)
    else $error("error flag survived the end of the frame");

endmodule

>>> hw/rtl/bm3_fifo.sv
// ----------------------------------------------------------------------------
// bm3_fifo: short queue of windows between front and back
// ----------------------------------------------------------------------------
module bm3_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  bm3_pkg::job_t                push_job,
  input  logic                         pop,
  output logic                         head_valid,
  output bm3_pkg::job_t                head,
  output logic [bm3_pkg::Q_CNT_W-1:0]  level
);
  import bm3_pkg::*;

  job_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_r, rptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + Q_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head       = slot_r[rptr_r];
  assign level      = cnt_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (cnt_r < Q_CNT_W'(Q_DEPTH)))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("queue underflow");

  a_pointers_track_level: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wptr_r == rptr_r))
    else $error("queue pointers disagree with level");

endmodule

>>> hw/rtl/bm3_back.sv
// ----------------------------------------------------------------------------
// bm3_back: morphology evaluation and output register
// Applies the structuring element to a queued window and holds the result
// beat until the sink takes it.
// ----------------------------------------------------------------------------
module bm3_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bm3_pkg::cfg_t              cfg,
  input  logic                       head_valid,
  input  bm3_pkg::job_t              head,
  output logic                       pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [bm3_pkg::PIX_W-1:0]  out_tdata,
  output logic                       out_tlast,
  output logic                       out_tuser
);
  import bm3_pkg::*;

  logic             out_v_r, out_v_nxt;
  logic [PIX_W-1:0] pix_r;
  logic             last_r, err_r;
  logic [1:0]       obj, bkg, centre;
  logic             er, dl, res;
  logic [8:0]       use_cell;

  always_comb begin
    obj    = {1'b0, cfg.fg};
    bkg    = {1'b0, ~cfg.fg};
    centre = head.win[4];
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        unique case (cfg.elem)
          ELEM_HORIZ: use_cell[3*r + c] = (r == 1);
          ELEM_VERT:  use_cell[3*r + c] = (c == 1);
          default:    use_cell[3*r + c] = cfg.mask[3*(2 - r) + c];
        endcase
      end
    end
    // Erosion drops to background on any background hit, dilation the reverse
    er = obj[0];
    dl = bkg[0];
    for (int i = 0; i < 9; i++) begin
      if (use_cell[i] && (head.win[i] == bkg)) begin
        er = bkg[0];
      end
      if (use_cell[i] && (head.win[i] == obj)) begin
        dl = obj[0];
      end
    end
    unique case (cfg.op)
      OP_ERODE:  res = er;
      OP_DILATE: res = dl;
      OP_OUTER:  res = (centre == {1'b0, dl}) ? bkg[0] : obj[0];
      default:   res = (centre == {1'b0, er}) ? bkg[0] : obj[0];
    endcase
    if (!head.proc) begin
      res = 1'b1;
    end
  end

  assign pop = head_valid && (!out_v_r || out_tready);

  always_comb begin
    out_v_nxt = out_v_r;
    if (pop) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pix_r  <= res ? '1 : '0;
      last_r <= head.last;
      err_r  <= head.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = pix_r;
  assign out_tlast  = last_r;
  assign out_tuser  = err_r;

endmodule

>>> hw/rtl/binary_morphology_3x3.sv
// ----------------------------------------------------------------------------
// binary_morphology_3x3: streaming 3x3 binary erosion / dilation / border
// Raster-order pixels in, one morphology result per centre pixel out.
// ----------------------------------------------------------------------------
//
// Channel | Direction | Beat contents
// --------+-----------+-------------------------------------------------------
// in_     | sink      | tdata = pixel_in[7:0]; tuser = kind (1 = skipped beat inside a frame)
// out_    | source    | tdata = pixel_out[7:0]; tlast = frame_last;
//         |           | tuser = frame_error
// cfg_    | write     | cfg_addr = register index, cfg_data = value
//
// Throughput is one beat per clock, set by the line store that is read on
// intake and written back in the next cycle through its own write port. A result
// beat passes from the window stage through the queue to the output register;
// in stream terms results lag the input by frame_width+1 beats, so flush beats
// drain a frame. After reset the line store is swept to zero (one entry per
// clock, MAX_WIDTH entries); in_tready stays low meanwhile, config writes
// are taken. A stalled out_ side fills the four-entry queue, then in_tready
// drops.
// ----------------------------------------------------------------------------
module binary_morphology_3x3 (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bm3_pkg::PIX_W-1:0]        in_tdata,   // [7:0] pixel_in
  input  logic                             in_tuser,   // [0] kind
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bm3_pkg::PIX_W-1:0]        out_tdata,  // [7:0] pixel_out
  output logic                             out_tlast,
  output logic                             out_tuser,  // [0] frame_error
  // Configuration write port
  input  logic                             cfg_we,
  input  logic [bm3_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [bm3_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bm3_pkg::*;

  cfg_t               cfg;
  width_upd_t         wupd;
  logic               push, pop, head_valid;
  job_t               push_job, head;
  logic [Q_CNT_W-1:0] q_level;

  // Register file; keeps the clamped sizes and the frame pixel total
  bm3_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg),
    .wupd     (wupd)
  );

  // Intake: position counters, frame restart, line store and window
  bm3_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg),
    .wupd      (wupd),
    .q_level   (q_level),
    .push      (push),
    .push_job  (push_job)
  );

  // Decouple the window stage from output back-pressure
  bm3_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .level      (q_level)
  );

  // Evaluate the element and hold the result beat
  bm3_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
